>>> sv/jlcg_pkg.sv
// Shared types and constants for the 48-bit LCG random generator.
package jlcg_pkg;

	localparam int unsigned STATE_W = 48;
	localparam int unsigned UADDR_W = 6;

	localparam logic [STATE_W-1:0] LCG_MULT = 48'h0005_DEEC_E66D;
	localparam logic [STATE_W-1:0] LCG_ADD  = 48'h0000_0000_000B;

	// Request kinds
	localparam logic [2:0] KIND_INT   = 3'd0;
	localparam logic [2:0] KIND_BOUND = 3'd1;
	localparam logic [2:0] KIND_LONG  = 3'd2;
	localparam logic [2:0] KIND_FLT   = 3'd3;
	localparam logic [2:0] KIND_DBL   = 3'd4;
	localparam logic [2:0] KIND_BOOL  = 3'd5;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] bound;
	} in_item_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic               error;
	} out_item_t;

	// Datapath micro-ops
	typedef enum logic [3:0] {
		OP_NOP  = 4'd0,  // result zero, no error
		OP_M0   = 4'd1,  // acc = state[15:0] * mult
		OP_M1   = 4'd2,  // acc += state[31:16] * mult << 16
		OP_M2   = 4'd3,  // acc += state[47:32] * mult << 32
		OP_ADV  = 4'd4,  // state = acc + add
		OP_HI   = 4'd5,  // hold top 32 state bits
		OP_INT  = 4'd6,
		OP_LONG = 4'd7,
		OP_DBL  = 4'd8,
		OP_FLT  = 4'd9,
		OP_BOOL = 4'd10,
		OP_POW2 = 4'd11,
		OP_DIVI = 4'd12, // load draw, clear remainder
		OP_DIVS = 4'd13, // one restoring divide step
		OP_CHK  = 4'd14, // remainder result, rejection test
		OP_ERR  = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		J_NONE = 2'd0,
		J_DIV  = 2'd1, // divide bits remain
		J_REJ  = 2'd2  // draw rejected
	} jcond_t;

	typedef struct packed {
		op_t                op;
		jcond_t             cond;
		logic [UADDR_W-1:0] target;
		logic               done;
	} ucode_t;

	typedef struct packed {
		logic en;
		op_t  op;
	} ctrl_t;

	typedef struct packed {
		logic div_more;
		logic reject;
	} status_t;

endpackage

>>> sv/jlcg_sequencer.sv
// Microcode sequencer: program ROM, step counter, dispatch and jumps.
module jlcg_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [2:0]                  kind,
	input  logic [31:0]                 bound,
	input  jlcg_pkg::status_t           status,
	input  logic                        out_free,
	output logic                        busy,
	output logic                        fire,
	output jlcg_pkg::ctrl_t             ctrl
);

	localparam int unsigned AW = jlcg_pkg::UADDR_W;

	localparam logic [AW-1:0] A_INT  = 6'd0;
	localparam logic [AW-1:0] A_LONG = 6'd5;
	localparam logic [AW-1:0] A_DBL  = 6'd15;
	localparam logic [AW-1:0] A_FLT  = 6'd25;
	localparam logic [AW-1:0] A_BOOL = 6'd30;
	localparam logic [AW-1:0] A_POW2 = 6'd35;
	localparam logic [AW-1:0] A_DIV  = 6'd40;
	localparam logic [AW-1:0] A_DIVS = 6'd45;
	localparam logic [AW-1:0] A_ERR  = 6'd47;
	localparam logic [AW-1:0] A_NOP  = 6'd48;

	function automatic jlcg_pkg::ucode_t uw(jlcg_pkg::op_t op, jlcg_pkg::jcond_t cond,
			logic [AW-1:0] target, logic done);
		jlcg_pkg::ucode_t w;
		w.op     = op;
		w.cond   = cond;
		w.target = target;
		w.done   = done;
		return w;
	endfunction

	// Program: every generator advance is M0, M1, M2, ADV.
	function automatic jlcg_pkg::ucode_t rom(logic [AW-1:0] a);
		jlcg_pkg::ucode_t w;
		unique case (a) inside
			6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25, 6'd30, 6'd35, 6'd40:
				w = uw(jlcg_pkg::OP_M0, jlcg_pkg::J_NONE, '0, 1'b0);
			6'd1, 6'd6, 6'd11, 6'd16, 6'd21, 6'd26, 6'd31, 6'd36, 6'd41:
				w = uw(jlcg_pkg::OP_M1, jlcg_pkg::J_NONE, '0, 1'b0);
			6'd2, 6'd7, 6'd12, 6'd17, 6'd22, 6'd27, 6'd32, 6'd37, 6'd42:
				w = uw(jlcg_pkg::OP_M2, jlcg_pkg::J_NONE, '0, 1'b0);
			6'd3, 6'd8, 6'd13, 6'd18, 6'd23, 6'd28, 6'd33, 6'd38, 6'd43:
				w = uw(jlcg_pkg::OP_ADV, jlcg_pkg::J_NONE, '0, 1'b0);
			6'd9, 6'd19:
				w = uw(jlcg_pkg::OP_HI, jlcg_pkg::J_NONE, '0, 1'b0);
			6'd4:  w = uw(jlcg_pkg::OP_INT, jlcg_pkg::J_NONE, '0, 1'b1);
			6'd14: w = uw(jlcg_pkg::OP_LONG, jlcg_pkg::J_NONE, '0, 1'b1);
			6'd24: w = uw(jlcg_pkg::OP_DBL, jlcg_pkg::J_NONE, '0, 1'b1);
			6'd29: w = uw(jlcg_pkg::OP_FLT, jlcg_pkg::J_NONE, '0, 1'b1);
			6'd34: w = uw(jlcg_pkg::OP_BOOL, jlcg_pkg::J_NONE, '0, 1'b1);
			6'd39: w = uw(jlcg_pkg::OP_POW2, jlcg_pkg::J_NONE, '0, 1'b1);
			6'd44: w = uw(jlcg_pkg::OP_DIVI, jlcg_pkg::J_NONE, '0, 1'b0);
			6'd45: w = uw(jlcg_pkg::OP_DIVS, jlcg_pkg::J_DIV, A_DIVS, 1'b0);
			6'd46: w = uw(jlcg_pkg::OP_CHK, jlcg_pkg::J_REJ, A_DIV, 1'b1);
			6'd47: w = uw(jlcg_pkg::OP_ERR, jlcg_pkg::J_NONE, '0, 1'b1);
			default: w = uw(jlcg_pkg::OP_NOP, jlcg_pkg::J_NONE, '0, 1'b1);
		endcase
		return w;
	endfunction

	logic              busy_q;
	logic [AW-1:0]     pc_q;
	logic [AW-1:0]     entry;
	jlcg_pkg::ucode_t  word;
	logic              jump;
	logic              bad_bound;
	logic              pow2;

	assign bad_bound = (bound == 32'd0) || bound[31];
	assign pow2      = ((bound & (bound - 32'd1)) == 32'd0);

	always_comb begin
		unique case (kind)
			jlcg_pkg::KIND_INT:   entry = A_INT;
			jlcg_pkg::KIND_BOUND: entry = bad_bound ? A_ERR : (pow2 ? A_POW2 : A_DIV);
			jlcg_pkg::KIND_LONG:  entry = A_LONG;
			jlcg_pkg::KIND_FLT:   entry = A_FLT;
			jlcg_pkg::KIND_DBL:   entry = A_DBL;
			jlcg_pkg::KIND_BOOL:  entry = A_BOOL;
			default:              entry = A_NOP;
		endcase
	end

	assign word = rom(pc_q);

	always_comb begin
		unique case (word.cond)
			jlcg_pkg::J_DIV: jump = status.div_more;
			jlcg_pkg::J_REJ: jump = status.reject;
			default:         jump = 1'b0;
		endcase
	end

	assign busy    = busy_q;
	assign fire    = busy_q && !jump && word.done && out_free;
	assign ctrl.en = busy_q;
	assign ctrl.op = word.op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= entry;
		end else if (busy_q) begin
			if (jump) begin
				pc_q <= word.target;
			end else if (word.done) begin
				// hold on the last step until the output slot frees up
				if (out_free) begin
					busy_q <= 1'b0;
				end
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

>>> sv/jlcg_datapath.sv
// Datapath: LCG state, chunked multiplier, serial divider, result forming.
module jlcg_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [jlcg_pkg::STATE_W-1:0] cfg_data,
	input  logic                       start,
	input  logic [31:0]                bound,
	input  jlcg_pkg::ctrl_t            ctrl,
	output jlcg_pkg::status_t          status,
	output jlcg_pkg::out_item_t        result
);

	localparam int unsigned SW = jlcg_pkg::STATE_W;

	logic [SW-1:0] state_q;
	logic [SW-1:0] acc_q;
	logic [31:0]   hi_q;
	logic [31:0]   bound_q;
	logic [30:0]   draw_q;
	logic [30:0]   rem_q;
	logic [4:0]    cnt_q;

	logic [15:0]   chunk;
	logic [50:0]   prod;
	logic [31:0]   trial;
	logic [31:0]   trial_sub;
	logic [31:0]   rej_sum;
	logic [62:0]   pow2_prod;
	logic [31:0]   top32;

	assign top32 = state_q[47:16];

	always_comb begin
		case (ctrl.op)
			jlcg_pkg::OP_M1: chunk = state_q[31:16];
			jlcg_pkg::OP_M2: chunk = state_q[47:32];
			default:         chunk = state_q[15:0];
		endcase
	end

	assign prod = 51'(chunk) * 51'(jlcg_pkg::LCG_MULT[34:0]);

	// restoring divide step
	assign trial     = {rem_q, draw_q[cnt_q]};
	assign trial_sub = trial - bound_q;

	// draw - rem + (bound - 1), sign bit tells a rejected draw
	assign rej_sum = {1'b0, draw_q} - {1'b0, rem_q} + (bound_q - 32'd1);

	assign pow2_prod = 63'(bound_q) * 63'(state_q[47:17]);

	assign status.div_more = (cnt_q != 5'd0);
	assign status.reject   = rej_sum[31];

	always_comb begin
		result.error = 1'b0;
		case (ctrl.op)
			jlcg_pkg::OP_INT:  result.value = {{32{top32[31]}}, top32};
			jlcg_pkg::OP_LONG: result.value = {hi_q, 32'd0} + {{32{top32[31]}}, top32};
			jlcg_pkg::OP_DBL:  result.value = {11'd0, hi_q[31:6], state_q[47:21]};
			jlcg_pkg::OP_FLT:  result.value = {40'd0, state_q[47:24]};
			jlcg_pkg::OP_BOOL: result.value = {63'd0, state_q[47]};
			jlcg_pkg::OP_POW2: result.value = {32'd0, pow2_prod[62:31]};
			jlcg_pkg::OP_CHK:  result.value = {33'd0, rem_q};
			jlcg_pkg::OP_ERR: begin
				result.value = '0;
				result.error = 1'b1;
			end
			default:           result.value = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jlcg_pkg::LCG_MULT;
			cnt_q   <= '0;
		end else if (cfg_we) begin
			state_q <= cfg_data ^ jlcg_pkg::LCG_MULT;
		end else if (ctrl.en) begin
			case (ctrl.op)
				jlcg_pkg::OP_ADV: state_q <= acc_q + jlcg_pkg::LCG_ADD;
				jlcg_pkg::OP_DIVI: cnt_q <= 5'd30;
				jlcg_pkg::OP_DIVS: cnt_q <= cnt_q - 5'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bound_q <= bound;
		end
		if (ctrl.en) begin
			case (ctrl.op)
				jlcg_pkg::OP_M0: acc_q <= prod[SW-1:0];
				jlcg_pkg::OP_M1: acc_q <= acc_q + {prod[31:0], 16'd0};
				jlcg_pkg::OP_M2: acc_q <= acc_q + {prod[15:0], 32'd0};
				jlcg_pkg::OP_HI: hi_q <= top32;
				jlcg_pkg::OP_DIVI: begin
					draw_q <= state_q[47:17];
					rem_q  <= '0;
				end
				jlcg_pkg::OP_DIVS: rem_q <= trial_sub[31] ? trial[30:0] : trial_sub[30:0];
				default: ;
			endcase
		end
	end

endmodule

>>> sv/java_lcg_random_generator.sv
// Top level of the 48-bit LCG random generator (java.util.Random scheme).
// Each advance of the state is three 16x35 partial products plus an add; bounds that are
// not a power of two take the modulo with a 31-step serial divider and redraw on rejection.
// One item at a time: the next is taken the cycle after its result loads.
// Reset: state = 0x5DEECE66D (seed 0), sequencer idle, no result pending.
module java_lcg_random_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  jlcg_pkg::in_item_t   in_item,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output jlcg_pkg::out_item_t  out_item,
	// seed register
	input  logic                 cfg_we,
	input  logic [jlcg_pkg::STATE_W-1:0] cfg_data
);

	logic                 busy;
	logic                 start;
	logic                 fire;
	logic                 out_free;
	jlcg_pkg::ctrl_t      ctrl;
	jlcg_pkg::status_t    status;
	jlcg_pkg::out_item_t  result;

	logic                 out_valid_q;
	jlcg_pkg::out_item_t  out_item_q;

	// A request beat is taken whenever the sequencer is idle, even while the
	// previous result still waits downstream.
	assign in_stall = busy;
	assign start    = in_valid && !busy;

	// Output slot is free when empty or draining this cycle.
	assign out_free = !out_valid_q || !out_stall;

	jlcg_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.kind     (in_item.kind),
		.bound    (in_item.bound),
		.status   (status),
		.out_free (out_free),
		.busy     (busy),
		.fire     (fire),
		.ctrl     (ctrl)
	);

	jlcg_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.start    (start),
		.bound    (in_item.bound),
		.ctrl     (ctrl),
		.status   (status),
		.result   (result)
	);

	// Result register: loaded on the final microcode step, cleared when the
	// beat leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
